// ===== rtl/first_fit_allocator_assert.svh =====
// Assertion macros for the first-fit allocator.
// Both expect clk_i in the scope of the module that uses them; FFA_ASSERT also expects rst_ni.
`ifndef FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Check prop at every clock edge outside reset
`define FFA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("first_fit_allocator: check failed");
// Check prop at every clock edge, reset included
`define FFA_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("first_fit_allocator: check failed");
`else
`define FFA_ASSERT(name, prop)
`define FFA_ASSERT_ALWAYS(name, prop)
`endif
`endif

// ===== rtl/ffa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

  // Table geometry
  localparam int unsigned FREE_SLOTS = 16;
  localparam int unsigned ADDR_BITS  = 16;
  localparam int unsigned LEN_BITS   = ADDR_BITS + 1;

  // Stream widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = ((ADDR_BITS + LEN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((ADDR_BITS + 7) / 8) * 8;
  localparam int unsigned STATUS_W   = 2;

  // Region after reset
  localparam logic [ADDR_BITS-1:0] RESET_START  = '0;
  localparam logic [LEN_BITS-1:0]  RESET_LENGTH = LEN_BITS'(600);
  localparam logic [LEN_BITS-1:0]  ADDR_SPAN    = LEN_BITS'(1) << ADDR_BITS;

  // Configuration register indexes
  localparam logic REG_REGION_START  = 1'b0;
  localparam logic REG_REGION_LENGTH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_NO_FIT = 2'd1,
    STATUS_FULL   = 2'd2
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  // Update broadcast to every cell
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_SHRINK,
    CMD_REMOVE,
    CMD_JOIN_LOW,
    CMD_JOIN_HIGH,
    CMD_JOIN_BOTH,
    CMD_INSERT
  } cmd_e;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EVAL,
    ST_APPLY
  } state_e;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] start;
    logic [LEN_BITS-1:0]  length;
  } extent_t;

  typedef struct packed {
    cmd_e                 cmd;
    logic                 eval;
    op_e                  op;
    logic [ADDR_BITS-1:0] base;
    logic [LEN_BITS-1:0]  size;
    logic [ADDR_BITS-1:0] load_start;
    logic [LEN_BITS-1:0]  load_length;
  } cell_ctrl_t;

  typedef struct packed {
    logic                 hit;
    logic                 remove;
    logic                 join_low;
    logic                 join_high;
    logic [ADDR_BITS-1:0] grant;
  } cell_status_t;

endpackage

`default_nettype wire

// ===== rtl/ffa_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffa_cell import ffa_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         first_i,
  input  cell_ctrl_t   ctrl_i,
  input  extent_t      left_i,
  input  extent_t      right_i,
  input  logic         before_i,
  input  logic         next_after_i,
  output logic         after_o,
  output extent_t      ext_o,
  output cell_status_t stat_o
);

  extent_t              ext_q, ext_d;
  logic                 flag_q, flag_d;
  logic                 len_eq_q, len_eq_d;
  logic                 end_eq_q, end_eq_d;
  logic                 start_eq_q, start_eq_d;
  logic                 sel, prev_sel;
  logic [LEN_BITS-1:0]  end_addr, free_end;

  // Compare this entry against the request
  always_comb begin
    end_addr = LEN_BITS'(ext_q.start) + ext_q.length;
    free_end = LEN_BITS'(ctrl_i.base) + ctrl_i.size;
    if (ctrl_i.op == OP_ALLOC) begin
      flag_d = ext_q.valid && (ext_q.length >= ctrl_i.size);
    end else begin
      flag_d = !(ext_q.valid && (ext_q.start < ctrl_i.base));
    end
    len_eq_d   = ext_q.length == ctrl_i.size;
    end_eq_d   = end_addr == LEN_BITS'(ctrl_i.base);
    start_eq_d = LEN_BITS'(ext_q.start) == free_end;
  end

  // Position in the row: selected cell, cells at or after it, cell just before it
  assign after_o  = before_i | flag_q;
  assign sel      = flag_q & ~before_i;
  assign prev_sel = ~after_o & next_after_i;

  always_comb begin
    stat_o.hit       = sel;
    stat_o.remove    = sel & len_eq_q;
    stat_o.join_low  = prev_sel & end_eq_q;
    stat_o.join_high = sel & ext_q.valid & start_eq_q;
    stat_o.grant     = sel ? ext_q.start : '0;
  end

  // Apply the broadcast update, pulling from a neighbor where the row shifts
  always_comb begin
    ext_d = ext_q;
    case (ctrl_i.cmd)
      CMD_LOAD: begin
        ext_d.valid  = first_i && (ctrl_i.load_length != '0);
        ext_d.start  = ctrl_i.load_start;
        ext_d.length = ctrl_i.load_length;
      end
      CMD_SHRINK: begin
        if (sel) begin
          ext_d.start  = ext_q.start + ctrl_i.size[ADDR_BITS-1:0];
          ext_d.length = ext_q.length - ctrl_i.size;
        end
      end
      CMD_REMOVE: begin
        if (after_o) ext_d = right_i;
      end
      CMD_JOIN_LOW: begin
        if (prev_sel) ext_d.length = ext_q.length + ctrl_i.size;
      end
      CMD_JOIN_HIGH: begin
        if (sel) begin
          ext_d.start  = ctrl_i.base;
          ext_d.length = ext_q.length + ctrl_i.size;
        end
      end
      CMD_JOIN_BOTH: begin
        if (prev_sel) begin
          ext_d.length = ext_q.length + ctrl_i.size + right_i.length;
        end else if (after_o) begin
          ext_d = right_i;
        end
      end
      CMD_INSERT: begin
        if (sel) begin
          ext_d.valid  = 1'b1;
          ext_d.start  = ctrl_i.base;
          ext_d.length = ctrl_i.size;
        end else if (after_o) begin
          ext_d = left_i;
        end
      end
      default: ;
    endcase
  end

  // Hold the compare results from the evaluation cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q     <= 1'b0;
      len_eq_q   <= 1'b0;
      end_eq_q   <= 1'b0;
      start_eq_q <= 1'b0;
    end else if (ctrl_i.eval) begin
      flag_q     <= flag_d;
      len_eq_q   <= len_eq_d;
      end_eq_q   <= end_eq_d;
      start_eq_q <= start_eq_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q.valid  <= 1'b0;
      ext_q.start  <= RESET_START;
      ext_q.length <= RESET_LENGTH;
    end else begin
      ext_q <= ext_d;
    end
  end

  assign ext_o = ext_q;

endmodule

`default_nettype wire

// ===== rtl/first_fit_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Dir | Payload
// ---------+-----+---------------------------------------------------------
// s_axis   | in  | tdata: base[15:0], size[32:16], zero pad; tuser: op
// m_axis   | out | tdata: granted_address[15:0]; tuser: status
// cfg      | in  | cfg_index_i selects region_start / region_length
//
// An item goes through accept, compare in every cell, update the row, in that order;
// the next item is accepted only after the update. The row of cells is the free table;
// an update shifts it by one cell at most. After reset the ST_INIT state loads the region
// into the row before s_axis_tready rises. A configuration write reloads the row in the cycle it is taken.
// A result waiting on m_axis holds the update cycle until the output frees up.

module first_fit_allocator import ffa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [LEN_BITS-1:0]   cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // base, size, zero pad
  input  logic                  s_axis_tuser,   // op
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // granted_address
  output logic [STATUS_W-1:0]   m_axis_tuser    // status
);

`include "first_fit_allocator_assert.svh"

  state_e               state_q, state_d;
  logic [ADDR_BITS-1:0] region_start_q, region_start_d;
  logic [LEN_BITS-1:0]  region_length_q, region_length_d;
  op_e                  op_q;
  logic [ADDR_BITS-1:0] base_q;
  logic [LEN_BITS-1:0]  size_q;
  logic                 out_valid_q;
  logic [ADDR_BITS-1:0] out_addr_q;
  status_e              out_status_q;

  logic                 in_acc, out_load;
  logic [ADDR_BITS-1:0] in_base;
  logic [LEN_BITS-1:0]  in_size, in_limit, in_size_c;
  logic [LEN_BITS-1:0]  load_limit, load_length;
  cmd_e                 cmd;
  logic                 eval;
  logic [ADDR_BITS-1:0] res_addr;
  status_e              res_status;
  cell_ctrl_t           ctrl;

  extent_t              ext   [FREE_SLOTS];
  cell_status_t         stat  [FREE_SLOTS];
  logic [FREE_SLOTS-1:0] after_vec, valid_vec, hit_vec;
  logic                 any_hit, any_remove, any_low, any_high;
  logic [ADDR_BITS-1:0] grant;

  // Input unpacking; clip a free at the top of the address space
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign in_base   = s_axis_tdata[ADDR_BITS-1:0];
  assign in_size   = s_axis_tdata[ADDR_BITS +: LEN_BITS];
  assign in_limit  = ADDR_SPAN - LEN_BITS'(in_base);
  assign in_size_c = ((op_e'(s_axis_tuser) == OP_FREE) && (in_size > in_limit)) ?
                     in_limit : in_size;

  // Region registers and the clipped region loaded into the row
  always_comb begin
    region_start_d  = region_start_q;
    region_length_d = region_length_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_REGION_START:  region_start_d  = cfg_data_i[ADDR_BITS-1:0];
        REG_REGION_LENGTH: region_length_d = cfg_data_i;
        default: ;
      endcase
    end
    load_limit  = ADDR_SPAN - LEN_BITS'(region_start_d);
    load_length = (region_length_d > load_limit) ? load_limit : region_length_d;
  end

  // Combine what the cells report
  always_comb begin
    any_hit    = 1'b0;
    any_remove = 1'b0;
    any_low    = 1'b0;
    any_high   = 1'b0;
    grant      = '0;
    for (int k = 0; k < FREE_SLOTS; k++) begin
      any_hit    = any_hit | stat[k].hit;
      any_remove = any_remove | stat[k].remove;
      any_low    = any_low | stat[k].join_low;
      any_high   = any_high | stat[k].join_high;
      grant      = grant | stat[k].grant;
      valid_vec[k] = ext[k].valid;
      hit_vec[k]   = stat[k].hit;
    end
  end

  // Sequencer: next state, cell command and result
  always_comb begin
    state_d       = state_q;
    cmd           = CMD_HOLD;
    eval          = 1'b0;
    out_load      = 1'b0;
    s_axis_tready = 1'b0;
    res_addr      = '0;
    res_status    = STATUS_OK;
    case (state_q)
      ST_INIT: begin
        cmd     = CMD_LOAD;
        state_d = ST_IDLE;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        eval    = 1'b1;
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          if (op_q == OP_ALLOC) begin
            if (any_hit) begin
              res_addr = grant;
              cmd      = any_remove ? CMD_REMOVE : CMD_SHRINK;
            end else begin
              res_status = STATUS_NO_FIT;
            end
          end else if (size_q != '0) begin
            if (any_low && any_high) begin
              cmd = CMD_JOIN_BOTH;
            end else if (any_low) begin
              cmd = CMD_JOIN_LOW;
            end else if (any_high) begin
              cmd = CMD_JOIN_HIGH;
            end else if (valid_vec[FREE_SLOTS-1]) begin
              res_status = STATUS_FULL;
            end else begin
              cmd = CMD_INSERT;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // Reload the row on any register write
    if (cfg_we_i) cmd = CMD_LOAD;
  end

  always_comb begin
    ctrl.cmd         = cmd;
    ctrl.eval        = eval;
    ctrl.op          = op_q;
    ctrl.base        = base_q;
    ctrl.size        = size_q;
    ctrl.load_start  = region_start_d;
    ctrl.load_length = load_length;
  end

  // Row of table cells
  for (genvar k = 0; k < FREE_SLOTS; k++) begin : g_cell
    extent_t left_ext, right_ext;
    logic    prev_after, next_after;
    if (k == 0) begin : g_head
      assign left_ext   = '0;
      assign prev_after = 1'b0;
    end else begin : g_body
      assign left_ext   = ext[k-1];
      assign prev_after = after_vec[k-1];
    end
    if (k == FREE_SLOTS - 1) begin : g_tail
      assign right_ext  = '0;
      assign next_after = 1'b1;
    end else begin : g_inner
      assign right_ext  = ext[k+1];
      assign next_after = after_vec[k+1];
    end
    ffa_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .first_i      (k == 0),
      .ctrl_i       (ctrl),
      .left_i       (left_ext),
      .right_i      (right_ext),
      .before_i     (prev_after),
      .next_after_i (next_after),
      .after_o      (after_vec[k]),
      .ext_o        (ext[k]),
      .stat_o       (stat[k])
    );
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_INIT;
      region_start_q  <= RESET_START;
      region_length_q <= RESET_LENGTH;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      region_start_q  <= region_start_d;
      region_length_q <= region_length_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_e'(s_axis_tuser);
      base_q <= in_base;
      size_q <= in_size_c;
    end
    if (out_load) begin
      out_addr_q   <= res_addr;
      out_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_addr_q);
  assign m_axis_tuser  = out_status_q;

  `FFA_ASSERT(a_single_select, $onehot0(hit_vec))
  `FFA_ASSERT(a_valid_prefix, ((valid_vec >> 1) & ~valid_vec) == '0)
  `FFA_ASSERT(a_result_due, in_acc |-> ##3 (m_axis_tvalid || state_q == ST_APPLY))
  `FFA_ASSERT(a_grant_only_ok, m_axis_tvalid && m_axis_tuser != STATUS_OK |-> m_axis_tdata == '0)

endmodule

`default_nettype wire
